/* hw/rtl/bfpe_pkg.sv */
// Shared types and constants for the brainfuck program executor.
`timescale 1ns / 1ps

package bfpe_pkg;

    typedef enum logic [1:0] {
        OPER_CLEAR  = 2'd0,
        OPER_APPEND = 2'd1,
        OPER_QUEUE  = 2'd2,
        OPER_RUN    = 2'd3
    } oper_t;

    typedef enum logic [2:0] {
        CMD_INC   = 3'd0,
        CMD_DEC   = 3'd1,
        CMD_LEFT  = 3'd2,
        CMD_RIGHT = 3'd3,
        CMD_PRINT = 3'd4,
        CMD_READ  = 3'd5,
        CMD_OPEN  = 3'd6,
        CMD_CLOSE = 3'd7
    } cmd_code_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_UNMATCHED  = 3'd1,
        STAT_STEPS      = 3'd2,
        STAT_OUTPUT     = 3'd3,
        STAT_PROG_FULL  = 3'd4,
        STAT_QUEUE_FULL = 3'd5
    } status_t;

    typedef struct packed {
        oper_t     operation;
        cmd_code_t command_code;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        status_t    status;
        logic       edge_hit;
        logic       input_underrun;
    } result_t;

    typedef struct packed {
        logic cell_we;
        logic edge_hit;
        logic underrun;
        logic pop;
        logic cell_zero;
    } alu_flags_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    localparam logic [5:0]  MAX_PRINTS        = 6'd63;
    localparam logic [15:0] STEP_LIMIT_RESET  = 16'hFFFF;
    localparam logic        REG_STEP_LIMIT    = 1'b0;

endpackage

/* hw/rtl/bfpe_alu.sv */
// Shared execution unit: cell update, pointer move and zero test for one command.
`timescale 1ns / 1ps

module bfpe_alu #(
    parameter int TAPE_DEPTH = 128,
    parameter int PW         = 7
) (
    input  bfpe_pkg::cmd_code_t  code,
    input  logic [7:0]           cell_val,
    input  logic [PW-1:0]        ptr,
    input  logic [7:0]           q_data,
    input  logic                 q_empty,
    output logic [7:0]           cell_new,
    output logic [PW-1:0]        ptr_new,
    output bfpe_pkg::alu_flags_t flags
);
    import bfpe_pkg::*;

    logic [7:0] sum;

    assign sum = cell_val + ((code == CMD_DEC) ? 8'hFF : 8'h01);

    always_comb
    begin
        cell_new = sum;
        ptr_new  = ptr;
        flags    = '0;
        flags.cell_zero = (cell_val == 8'd0);
        case (code)
            CMD_INC, CMD_DEC:
            begin
                flags.cell_we = 1'b1;
            end
            CMD_LEFT:
            begin
                if (ptr == '0)
                begin
                    flags.edge_hit = 1'b1;
                end
                else
                begin
                    ptr_new = ptr - PW'(1);
                end
            end
            CMD_RIGHT:
            begin
                if (ptr == PW'(TAPE_DEPTH - 1))
                begin
                    flags.edge_hit = 1'b1;
                end
                else
                begin
                    ptr_new = ptr + PW'(1);
                end
            end
            CMD_READ:
            begin
                flags.cell_we = 1'b1;
                if (q_empty)
                begin
                    cell_new       = 8'd0;
                    flags.underrun = 1'b1;
                end
                else
                begin
                    cell_new  = q_data;
                    flags.pop = 1'b1;
                end
            end
            default:
            begin
                cell_new = sum;
            end
        endcase
    end

endmodule

/* hw/rtl/bfpe_in_queue.sv */
// Input byte queue: first-in first-out memory with a registered head read.
`timescale 1ns / 1ps

module bfpe_in_queue #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          push_data,
    input  logic                pop,
    output logic [7:0]          rd_data,
    output bfpe_pkg::q_status_t q_status
);
    import bfpe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    rd_reg;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign rd_data        = rd_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !q_status.full)
        begin
            tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end
        else if (pop && !q_status.empty)
        begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !q_status.full)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_reg <= mem[head_reg];
    end

endmodule

/* hw/rtl/brainfuck_program_executor.sv */
// Top level of the brainfuck program executor: sequencer, program and tape memories.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low, and every item ends with one
// status result marked by is_last; results appear for one cycle on result_valid and
// cannot be held off. Clear, append and queue items answer in the next cycle and the
// block is ready again at once. A run first checks the brackets, reading and then
// evaluating each program command in turn; it then executes each command by a fetch
// and an execute through the shared unit, and a bracket jump reads and evaluates
// every command it passes over. After reset the tape is cleared one cell per cycle
// with busy high until the last cell; configuration writes are taken at any time.
module brainfuck_program_executor #(
    parameter int PROGRAM_DEPTH     = 128,
    parameter int TAPE_DEPTH        = 128,
    parameter int INPUT_QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bfpe_pkg::item_t   item,
    output logic              busy,
    output logic              result_valid,
    output bfpe_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bfpe_pkg::*;

    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int PLW = $clog2(PROGRAM_DEPTH + 1);
    localparam int TAW = $clog2(TAPE_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_CHK_RD    = 8'b0000_0100,
        S_CHK_EVAL  = 8'b0000_1000,
        S_FETCH     = 8'b0001_0000,
        S_EXEC      = 8'b0010_0000,
        S_SCAN_RD   = 8'b0100_0000,
        S_SCAN_EVAL = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [PLW-1:0] pc_reg, pc_next;
    logic [PLW-1:0] len_reg, len_next;
    logic [PLW-1:0] depth_reg, depth_next;
    logic [15:0]    steps_reg, steps_next;
    logic [5:0]     nprint_reg, nprint_next;
    logic           edge_reg, edge_next;
    logic           under_reg, under_next;
    logic           dir_reg, dir_next;
    logic [TAW-1:0] ptr_reg, ptr_next;
    logic [TAW-1:0] clr_reg, clr_next;
    result_t        res_reg, res_next;
    logic           res_valid_reg, res_valid_next;
    logic [15:0]    step_limit_reg;

    cmd_code_t      prog_mem [PROGRAM_DEPTH];
    cmd_code_t      prog_rd_reg;
    logic           prog_we;
    logic [7:0]     tape_mem [TAPE_DEPTH];
    logic [7:0]     tape_rd_reg;
    logic           tape_we;
    logic [TAW-1:0] tape_waddr;
    logic [7:0]     tape_wdata;

    logic           q_push;
    logic           q_pop;
    logic [7:0]     q_data;
    q_status_t      q_status;

    logic [7:0]     alu_cell;
    logic [TAW-1:0] alu_ptr;
    alu_flags_t     alu_flags;

    cmd_code_t      scan_target;
    cmd_code_t      scan_other;
    logic [PLW-1:0] scan_pc;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_STEP_LIMIT) ? {16'd0, step_limit_reg} : 32'd0;

    bfpe_alu #(
        .TAPE_DEPTH (TAPE_DEPTH),
        .PW         (TAW)
    ) u_alu (
        .code     (prog_rd_reg),
        .cell_val (tape_rd_reg),
        .ptr      (ptr_reg),
        .q_data   (q_data),
        .q_empty  (q_status.empty),
        .cell_new (alu_cell),
        .ptr_new  (alu_ptr),
        .flags    (alu_flags)
    );

    bfpe_in_queue #(
        .DEPTH (INPUT_QUEUE_DEPTH)
    ) u_in_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (item.data_byte),
        .pop       (q_pop),
        .rd_data   (q_data),
        .q_status  (q_status)
    );

    assign scan_target = dir_reg ? CMD_OPEN : CMD_CLOSE;
    assign scan_other  = dir_reg ? CMD_CLOSE : CMD_OPEN;
    assign scan_pc     = dir_reg ? pc_reg - PLW'(1) : pc_reg + PLW'(1);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        steps_next     = steps_reg;
        nprint_next    = nprint_reg;
        edge_next      = edge_reg;
        under_next     = under_reg;
        dir_next       = dir_reg;
        ptr_next       = ptr_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        prog_we        = 1'b0;
        tape_we        = 1'b0;
        tape_waddr     = ptr_reg;
        tape_wdata     = alu_cell;
        q_push         = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                tape_wdata = 8'd0;
                clr_next   = clr_reg + TAW'(1);
                if (clr_reg == TAW'(TAPE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '{out_byte: 8'd0, is_last: 1'b1, status: STAT_OK,
                                 edge_hit: 1'b0, input_underrun: 1'b0};
                    case (item.operation)
                        OPER_CLEAR:
                        begin
                            len_next       = '0;
                            res_valid_next = 1'b1;
                        end
                        OPER_APPEND:
                        begin
                            res_valid_next = 1'b1;
                            if (len_reg == PLW'(PROGRAM_DEPTH))
                            begin
                                res_next.status = STAT_PROG_FULL;
                            end
                            else
                            begin
                                prog_we  = 1'b1;
                                len_next = len_reg + PLW'(1);
                            end
                        end
                        OPER_QUEUE:
                        begin
                            res_valid_next = 1'b1;
                            if (q_status.full)
                            begin
                                res_next.status = STAT_QUEUE_FULL;
                            end
                            else
                            begin
                                q_push = 1'b1;
                            end
                        end
                        default:
                        begin
                            pc_next     = '0;
                            depth_next  = '0;
                            steps_next  = '0;
                            nprint_next = '0;
                            edge_next   = 1'b0;
                            under_next  = 1'b0;
                            state_next  = S_CHK_RD;
                        end
                    endcase
                end
            end
            S_CHK_RD:
            begin
                if (pc_reg == len_reg)
                begin
                    if (depth_reg == '0)
                    begin
                        pc_next    = '0;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        res_next = '{out_byte: 8'd0, is_last: 1'b1, status: STAT_UNMATCHED,
                                     edge_hit: 1'b0, input_underrun: 1'b0};
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_CHK_EVAL;
                end
            end
            S_CHK_EVAL:
            begin
                pc_next    = pc_reg + PLW'(1);
                state_next = S_CHK_RD;
                if (prog_rd_reg == CMD_OPEN)
                begin
                    depth_next = depth_reg + PLW'(1);
                end
                else if (prog_rd_reg == CMD_CLOSE)
                begin
                    if (depth_reg == '0)
                    begin
                        res_next = '{out_byte: 8'd0, is_last: 1'b1, status: STAT_UNMATCHED,
                                     edge_hit: 1'b0, input_underrun: 1'b0};
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        depth_next = depth_reg - PLW'(1);
                    end
                end
            end
            S_FETCH:
            begin
                res_next = '{out_byte: 8'd0, is_last: 1'b1, status: STAT_OK,
                             edge_hit: edge_reg, input_underrun: under_reg};
                if (pc_reg >= len_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (steps_reg >= step_limit_reg)
                begin
                    res_next.status = STAT_STEPS;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                steps_next = steps_reg + 16'd1;
                pc_next    = pc_reg + PLW'(1);
                state_next = S_FETCH;
                tape_we    = alu_flags.cell_we;
                ptr_next   = alu_ptr;
                q_pop      = alu_flags.pop;
                edge_next  = edge_reg | alu_flags.edge_hit;
                under_next = under_reg | alu_flags.underrun;
                case (prog_rd_reg)
                    CMD_PRINT:
                    begin
                        res_valid_next = 1'b1;
                        if (nprint_reg == MAX_PRINTS)
                        begin
                            res_next = '{out_byte: 8'd0, is_last: 1'b1,
                                         status: STAT_OUTPUT, edge_hit: edge_reg,
                                         input_underrun: under_reg};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            res_next = '{out_byte: tape_rd_reg, is_last: 1'b0,
                                         status: STAT_OK, edge_hit: 1'b0,
                                         input_underrun: 1'b0};
                            nprint_next = nprint_reg + 6'd1;
                        end
                    end
                    CMD_OPEN:
                    begin
                        if (alu_flags.cell_zero)
                        begin
                            dir_next   = 1'b0;
                            depth_next = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_CLOSE:
                    begin
                        if (!alu_flags.cell_zero)
                        begin
                            dir_next   = 1'b1;
                            depth_next = '0;
                            pc_next    = pc_reg - PLW'(1);
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EVAL;
            end
            S_SCAN_EVAL:
            begin
                pc_next    = scan_pc;
                state_next = S_SCAN_RD;
                if (prog_rd_reg == scan_target)
                begin
                    if (depth_reg == '0)
                    begin
                        pc_next    = pc_reg + PLW'(1);
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        depth_next = depth_reg - PLW'(1);
                    end
                end
                else if (prog_rd_reg == scan_other)
                begin
                    depth_next = depth_reg + PLW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pc_reg         <= '0;
            len_reg        <= '0;
            depth_reg      <= '0;
            steps_reg      <= '0;
            nprint_reg     <= '0;
            edge_reg       <= 1'b0;
            under_reg      <= 1'b0;
            dir_reg        <= 1'b0;
            ptr_reg        <= '0;
            clr_reg        <= '0;
            res_valid_reg  <= 1'b0;
            step_limit_reg <= STEP_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            len_reg       <= len_next;
            depth_reg     <= depth_next;
            steps_reg     <= steps_next;
            nprint_reg    <= nprint_next;
            edge_reg      <= edge_next;
            under_reg     <= under_next;
            dir_reg       <= dir_next;
            ptr_reg       <= ptr_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_STEP_LIMIT))
            begin
                step_limit_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[len_reg[PAW-1:0]] <= item.command_code;
        end
        prog_rd_reg <= prog_mem[pc_reg[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rd_reg <= tape_mem[ptr_reg];
    end

endmodule

/* hw/rtl/bfpe_checker.sv */
// Port-level checks for the brainfuck program executor, bound to the top level.
`timescale 1ns / 1ps

module bfpe_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input bfpe_pkg::item_t   item,
    input logic              busy,
    input logic              result_valid,
    input bfpe_pkg::result_t result
);
    import bfpe_pkg::*;

    // Clear, append and queue transfers answer with their status in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation != OPER_RUN) |=> (result_valid && result.is_last))
    else $error("load item did not answer in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.operation == OPER_RUN) |=> busy)
    else $error("run item did not make the block busy");

    // Printed bytes carry no status and only appear while a run is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.is_last) |->
            (result.status == STAT_OK && !result.edge_hit && !result.input_underrun && busy))
    else $error("print result carries status or appears outside a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_last) |-> (result.out_byte == 8'd0))
    else $error("final status result has a nonzero byte");

endmodule

bind brainfuck_program_executor bfpe_checker u_bfpe_checker (.*);

/* bench/brainfuck_program_executor_checker.sv */
// Checker that predicts every result transfer of the brainfuck program executor and compares it.
`timescale 1ns / 1ps

module brainfuck_program_executor_checker #(
    parameter int PROG_DEPTH = 128,
    parameter int TAPE_DEPTH = 128,
    parameter int FIFO_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bfpe_pkg::item_t   item,
    input  logic              busy,
    input  logic              result_valid,
    input  bfpe_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                mismatches,
    output int                outstanding,
    output int                results_checked,
    output logic [5:0]        statuses_seen
);
    import bfpe_pkg::*;

    localparam logic [2:0] STEP_LIMIT_ADDR = 3'(4 * int'(REG_STEP_LIMIT));

    logic [15:0] step_limit_reg;
    cmd_code_t   prog_mem [PROG_DEPTH];
    int          prog_len;
    logic [7:0]  tape_mem [TAPE_DEPTH];
    int          tape_ptr;
    logic [7:0]  in_fifo [$];
    result_t     due_results [$];
    int          error_count;
    int          checked_count;
    logic [5:0]  seen_mask;

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h (result %0d)",
                                      name, got, want, checked_count));
    endtask

    function automatic result_t make_result(input logic [7:0] b, input logic last,
                                            input status_t st, input logic e,
                                            input logic u);
        result_t r;
        r.out_byte       = b;
        r.is_last        = last;
        r.status         = st;
        r.edge_hit       = e;
        r.input_underrun = u;
        return r;
    endfunction

    task automatic run_program();
        int        open_at [PROG_DEPTH];
        int        jump_to [PROG_DEPTH];
        int        depth;
        int        i;
        int        pc;
        int        steps;
        int        prints;
        logic      balanced;
        logic      edge_seen;
        logic      under_seen;
        status_t   st;
        cmd_code_t c;
        depth = 0;
        balanced = 1'b1;
        for (i = 0; i < prog_len; i++)
        begin
            if (prog_mem[i] == CMD_OPEN)
            begin
                open_at[depth] = i;
                depth++;
            end
            else if (prog_mem[i] == CMD_CLOSE)
            begin
                if (depth == 0)
                    balanced = 1'b0;
                else
                begin
                    depth--;
                    jump_to[i] = open_at[depth];
                    jump_to[open_at[depth]] = i;
                end
            end
        end
        if (!balanced || depth != 0)
        begin
            due_results.push_back(make_result(8'd0, 1'b1, STAT_UNMATCHED, 1'b0, 1'b0));
            return;
        end
        pc = 0;
        steps = 0;
        prints = 0;
        edge_seen = 1'b0;
        under_seen = 1'b0;
        st = STAT_OK;
        while (pc < prog_len)
        begin
            if (steps >= int'(step_limit_reg))
            begin
                st = STAT_STEPS;
                break;
            end
            steps++;
            c = prog_mem[pc];
            case (c)
                CMD_INC:   tape_mem[tape_ptr] = tape_mem[tape_ptr] + 8'd1;
                CMD_DEC:   tape_mem[tape_ptr] = tape_mem[tape_ptr] - 8'd1;
                CMD_LEFT:
                    if (tape_ptr == 0)
                        edge_seen = 1'b1;
                    else
                        tape_ptr--;
                CMD_RIGHT:
                    if (tape_ptr >= TAPE_DEPTH - 1)
                        edge_seen = 1'b1;
                    else
                        tape_ptr++;
                CMD_PRINT:
                    if (prints >= int'(MAX_PRINTS))
                        st = STAT_OUTPUT;
                    else
                    begin
                        due_results.push_back(make_result(tape_mem[tape_ptr], 1'b0,
                                                          STAT_OK, 1'b0, 1'b0));
                        prints++;
                    end
                CMD_READ:
                    if (in_fifo.size() == 0)
                    begin
                        tape_mem[tape_ptr] = 8'd0;
                        under_seen = 1'b1;
                    end
                    else
                        tape_mem[tape_ptr] = in_fifo.pop_front();
                CMD_OPEN:
                    if (tape_mem[tape_ptr] == 8'd0)
                        pc = jump_to[pc];
                CMD_CLOSE:
                    if (tape_mem[tape_ptr] != 8'd0)
                        pc = jump_to[pc];
            endcase
            if (st != STAT_OK)
                break;
            pc++;
        end
        due_results.push_back(make_result(8'd0, 1'b1, st, edge_seen, under_seen));
    endtask

    task automatic interpret_item(input item_t it);
        status_t st;
        st = STAT_OK;
        case (it.operation)
            OPER_CLEAR:
                prog_len = 0;
            OPER_APPEND:
                if (prog_len >= PROG_DEPTH)
                    st = STAT_PROG_FULL;
                else
                begin
                    prog_mem[prog_len] = it.command_code;
                    prog_len++;
                end
            OPER_QUEUE:
                if (in_fifo.size() >= FIFO_DEPTH)
                    st = STAT_QUEUE_FULL;
                else
                    in_fifo.push_back(it.data_byte);
            default:
            begin
                run_program();
                return;
            end
        endcase
        due_results.push_back(make_result(8'd0, 1'b1, st, 1'b0, 1'b0));
    endtask

    task automatic compare_result(input result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("result transfer %0h with nothing expected", got));
            return;
        end
        want = due_results.pop_front();
        check_field("out_byte", 32'(got.out_byte), 32'(want.out_byte));
        check_field("is_last", 32'(got.is_last), 32'(want.is_last));
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("edge_hit", 32'(got.edge_hit), 32'(want.edge_hit));
        check_field("input_underrun", 32'(got.input_underrun), 32'(want.input_underrun));
        if (want.is_last)
            seen_mask[want.status] = 1'b1;
        checked_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg = STEP_LIMIT_RESET;
            prog_len = 0;
            tape_ptr = 0;
            for (int i = 0; i < TAPE_DEPTH; i++)
                tape_mem[i] = 8'd0;
            in_fifo.delete();
            due_results.delete();
            error_count = 0;
            checked_count = 0;
            seen_mask = '0;
        end
        else
        begin
            if (result_valid)
                compare_result(result);
            if (start && !busy)
                interpret_item(item);
            if (psel && penable && pready && paddr == STEP_LIMIT_ADDR)
            begin
                if (pwrite)
                    step_limit_reg = pwdata[15:0];
                else
                    check_field("prdata", prdata, {16'd0, step_limit_reg});
            end
        end
        mismatches      <= error_count;
        outstanding     <= due_results.size();
        results_checked <= checked_count;
        statuses_seen   <= seen_mask;
    end

endmodule

/* bench/brainfuck_program_executor_test.sv */
// Stimulus and verdict for the brainfuck program executor, with the checker beside the block.
`timescale 1ns / 1ps

module brainfuck_program_executor_test;
    import bfpe_pkg::*;

    localparam int          PROG_DEPTH      = 128;
    localparam int          TAPE_DEPTH      = 128;
    localparam int          FIFO_DEPTH      = 16;
    localparam int          RANDOM_ITEMS    = 310;
    localparam int          PHASES          = 4;
    localparam int          TAIL_CYCLES     = 2 * PROG_DEPTH + 16;
    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam logic [2:0]  STEP_LIMIT_ADDR = 3'(4 * int'(REG_STEP_LIMIT));

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       item = '0;
    logic        busy;
    logic        result_valid;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    logic [5:0]  statuses_seen;

    int unsigned cycle_count = 0;
    int          item_count = 0;
    int          directed_count = 0;
    int          burst_left = 0;

    brainfuck_program_executor #(
        .PROGRAM_DEPTH     (PROG_DEPTH),
        .TAPE_DEPTH        (TAPE_DEPTH),
        .INPUT_QUEUE_DEPTH (FIFO_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    brainfuck_program_executor_checker #(
        .PROG_DEPTH (PROG_DEPTH),
        .TAPE_DEPTH (TAPE_DEPTH),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .item            (item),
        .busy            (busy),
        .result_valid    (result_valid),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .statuses_seen   (statuses_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("brainfuck_program_executor test failed");
            $finish;
        end
    end

    function automatic cmd_code_t rand_cmd();
        return cmd_code_t'($urandom_range(CMD_INC, CMD_CLOSE));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_item(input oper_t op, input cmd_code_t code, input logic [7:0] data);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            item <= {oper_t'($urandom_range(OPER_CLEAR, OPER_RUN)), rand_cmd(), rand_byte()};
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        item <= {op, code, data};
        do @(posedge clk); while (busy);
        item_count++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_step_limit(input logic [15:0] limit);
        apb_access(1'b1, STEP_LIMIT_ADDR, {16'd0, limit});
        apb_access(1'b0, STEP_LIMIT_ADDR, '0);
    endtask

    task automatic append_program(input int len, input logic balanced);
        int        i;
        int        depth;
        int        left_over;
        cmd_code_t c;
        depth = 0;
        for (i = 0; i < len; i++)
        begin
            left_over = len - i;
            c = rand_cmd();
            if (balanced)
            begin
                if (depth >= left_over)
                    c = CMD_CLOSE;
                else if (c == CMD_OPEN && depth + 1 >= left_over)
                    c = CMD_INC;
                else if (c == CMD_CLOSE && depth == 0)
                    c = CMD_DEC;
            end
            if (c == CMD_OPEN)
                depth++;
            else if (c == CMD_CLOSE && depth > 0)
                depth--;
            push_item(OPER_APPEND, c, rand_byte());
        end
    endtask

    task automatic random_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            push_item(OPER_CLEAR, rand_cmd(), rand_byte());
            append_program($urandom_range(1, 16), 1'b1);
            repeat ($urandom_range(0, 4)) push_item(OPER_QUEUE, rand_cmd(), rand_byte());
            push_item(OPER_RUN, rand_cmd(), rand_byte());
        end
        else if (kind < 75)
        begin
            push_item(OPER_CLEAR, rand_cmd(), rand_byte());
            append_program($urandom_range(1, 12), 1'b0);
            push_item(OPER_RUN, rand_cmd(), rand_byte());
        end
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 6))
                push_item(oper_t'($urandom_range(OPER_CLEAR, OPER_RUN)), rand_cmd(), rand_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 20)) push_item(OPER_QUEUE, rand_cmd(), rand_byte());
        end
    endtask

    initial
    begin
        int phase;
        logic [15:0] limit;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apb_access(1'b0, STEP_LIMIT_ADDR, '0);
        set_step_limit(STEP_LIMIT_RESET);

        push_item(OPER_RUN, rand_cmd(), rand_byte());
        push_item(OPER_QUEUE, rand_cmd(), 8'h00);
        push_item(OPER_QUEUE, rand_cmd(), 8'hFF);
        push_item(OPER_APPEND, CMD_LEFT, rand_byte());
        push_item(OPER_APPEND, CMD_READ, rand_byte());
        push_item(OPER_APPEND, CMD_PRINT, rand_byte());
        push_item(OPER_APPEND, CMD_READ, rand_byte());
        push_item(OPER_APPEND, CMD_PRINT, rand_byte());
        push_item(OPER_APPEND, CMD_READ, rand_byte());
        push_item(OPER_APPEND, CMD_PRINT, rand_byte());
        push_item(OPER_APPEND, CMD_DEC, rand_byte());
        push_item(OPER_APPEND, CMD_PRINT, rand_byte());
        push_item(OPER_RUN, rand_cmd(), rand_byte());
        // Walk to the right end of the tape, then spin on the last cell until it wraps.
        push_item(OPER_CLEAR, rand_cmd(), rand_byte());
        push_item(OPER_APPEND, CMD_DEC, rand_byte());
        push_item(OPER_APPEND, CMD_OPEN, rand_byte());
        push_item(OPER_APPEND, CMD_RIGHT, rand_byte());
        push_item(OPER_APPEND, CMD_INC, rand_byte());
        push_item(OPER_APPEND, CMD_CLOSE, rand_byte());
        push_item(OPER_RUN, rand_cmd(), rand_byte());
        push_item(OPER_APPEND, CMD_CLOSE, rand_byte());
        push_item(OPER_RUN, rand_cmd(), rand_byte());
        push_item(OPER_CLEAR, rand_cmd(), rand_byte());
        push_item(OPER_APPEND, CMD_INC, rand_byte());
        push_item(OPER_APPEND, CMD_OPEN, rand_byte());
        push_item(OPER_APPEND, CMD_PRINT, rand_byte());
        push_item(OPER_APPEND, CMD_CLOSE, rand_byte());
        push_item(OPER_RUN, rand_cmd(), rand_byte());
        directed_count = item_count;

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:       limit = 16'd1;
                1:       limit = 16'($urandom_range(2, 30));
                2:       limit = 16'($urandom_range(31, 300));
                default: limit = 16'd300;
            endcase
            set_step_limit(limit);
            if (phase == 0)
            begin
                push_item(OPER_CLEAR, rand_cmd(), rand_byte());
                repeat (PROG_DEPTH + 2)
                    push_item(OPER_APPEND, cmd_code_t'($urandom_range(CMD_INC, CMD_READ)),
                              rand_byte());
                push_item(OPER_RUN, rand_cmd(), rand_byte());
                repeat (FIFO_DEPTH + 2) push_item(OPER_QUEUE, rand_cmd(), rand_byte());
            end
            do
            begin
                random_sequence();
                if ($urandom_range(0, 15) == 0)
                    wait_idle();
            end
            while (item_count - directed_count < (phase + 1) * RANDOM_ITEMS / PHASES);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Sent %0d items (%0d directed) under %0d step limit settings.",
                 item_count, directed_count, PHASES + 1);
        $display("Checked %0d results with %0d mismatches; final status codes seen: %06b.",
                 results_checked, mismatches, statuses_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("brainfuck_program_executor test passed");
        else
            $display("brainfuck_program_executor test failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bfpe_pkg.sv
hw/rtl/bfpe_alu.sv
hw/rtl/bfpe_in_queue.sv
hw/rtl/brainfuck_program_executor.sv
hw/rtl/bfpe_checker.sv
bench/brainfuck_program_executor_checker.sv
bench/brainfuck_program_executor_test.sv
